[rtl/txrsp_pkg.sv]
// ----------------------------------------------------------------------------
// txrsp_pkg
// Shared types and constants for the transaction record stream parser.
// ----------------------------------------------------------------------------
package txrsp_pkg;

  // Default number of hash bytes at the head of a spend record.
  localparam int HASH_BYTES_DEF = 32;

  // Depth of the result queue in front of the output port.
  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  // CompactSize prefix bytes.
  localparam logic [7:0] CS_PREFIX_2 = 8'hFD;
  localparam logic [7:0] CS_PREFIX_4 = 8'hFE;

  // CompactSize value byte counts.
  localparam logic [3:0] CS_TOTAL_2 = 4'd2;
  localparam logic [3:0] CS_TOTAL_4 = 4'd4;
  localparam logic [3:0] CS_TOTAL_8 = 4'd8;

  // Byte counts of the fixed integer fields.
  localparam logic [3:0] INDEX_BYTES  = 4'd4;
  localparam logic [3:0] SEQ_BYTES    = 4'd4;
  localparam logic [3:0] AMOUNT_BYTES = 4'd8;

  // Configuration register map.
  localparam int          PADDR_W         = 3;
  localparam logic        REG_RECORD_KIND = 1'b0;

  typedef enum logic [1:0] {
    RK_SPEND   = 2'd0,
    RK_OUTPUT  = 2'd1,
    RK_WITNESS = 2'd2
  } record_kind_t;

  typedef enum logic [3:0] {
    FK_HASH_BYTE   = 4'd0,
    FK_INDEX       = 4'd1,
    FK_SCRIPT_LEN  = 4'd2,
    FK_SCRIPT_BYTE = 4'd3,
    FK_SEQUENCE    = 4'd4,
    FK_AMOUNT      = 4'd5,
    FK_ITEM_COUNT  = 4'd6,
    FK_ITEM_LEN    = 4'd7,
    FK_ITEM_BYTE   = 4'd8,
    FK_TRUNCATED   = 4'd9
  } field_kind_t;

  typedef enum logic [11:0] {
    PH_START   = 12'b0000_0000_0001,
    PH_HASH    = 12'b0000_0000_0010,
    PH_INDEX   = 12'b0000_0000_0100,
    PH_SLEN    = 12'b0000_0000_1000,
    PH_SCRIPT  = 12'b0000_0001_0000,
    PH_SEQ     = 12'b0000_0010_0000,
    PH_AMOUNT  = 12'b0000_0100_0000,
    PH_OSLEN   = 12'b0000_1000_0000,
    PH_OSCRIPT = 12'b0001_0000_0000,
    PH_COUNT   = 12'b0010_0000_0000,
    PH_ILEN    = 12'b0100_0000_0000,
    PH_ITEM    = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [63:0] field_value;
    logic        record_end;
  } out_word_t;

endpackage

[rtl/tx_record_stream_parser.sv]
// ----------------------------------------------------------------------------
// tx_record_stream_parser
// Byte-serial parser for back-to-back spend, output or witness records.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Word
//  in        input      in_valid / in_ready  in_word_t: one stream byte + end flag
//  out       output     out_valid/out_ready  out_word_t: one decoded field
//  apb       config     psel/penable/pready  record_kind at byte address 0
//
// Each accepted byte is parsed in the cycle of its acceptance: the parser
// state registers and a small result queue are written at that edge, so one
// byte is taken every cycle and its results are visible in the next cycle.
// A byte yields at most two words (a field and a truncation error); the
// result queue holds four words and in_ready falls when fewer than two
// entries are free, so the input stalls only while the output side stalls
// or after a run of truncation errors. Reset (rst, synchronous) returns the
// parser to a record start, empties the queue and sets record_kind to spend.
//
module tx_record_stream_parser
  import txrsp_pkg::*;
#(
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // Byte stream input.
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  // Field results.
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // The byte index must count through the hash and through an eight-byte
  // integer field, whichever is longer.
  localparam int IDX_W = ($clog2(HASH_BYTES + 1) > 4) ? $clog2(HASH_BYTES + 1) : 4;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [1:0] record_kind;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_kind <= RK_SPEND;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RECORD_KIND)) begin
      record_kind <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_RECORD_KIND) begin
      prdata = {30'd0, record_kind};
    end
  end

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  phase_t            phase, phase_next;
  logic [IDX_W-1:0]  field_byte_index, field_byte_index_next;
  logic [3:0]        field_byte_total, field_byte_total_next;
  logic [63:0]       value_acc, value_acc_next;
  logic [63:0]       bytes_remaining, bytes_remaining_next;
  logic [63:0]       items_remaining, items_remaining_next;

  logic              in_fire;
  logic              out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Shared datapath pieces used by the fixed-width and CompactSize fields.
  logic [7:0]        b;
  logic [IDX_W-1:0]  idx_inc;
  logic [63:0]       acc_ins;
  logic [63:0]       bytes_dec;
  logic [63:0]       items_dec;
  logic              cs_first;
  logic [3:0]        cs_total_sel;
  logic              cs_done;
  logic [63:0]       cs_val;

  assign b         = in_data.data_byte;
  assign idx_inc   = field_byte_index + 1'b1;
  assign acc_ins   = value_acc | ({56'd0, b} << {field_byte_index[2:0], 3'b000});
  assign bytes_dec = bytes_remaining - 64'd1;
  assign items_dec = items_remaining - 64'd1;

  // A CompactSize field is either a single byte below the first prefix, or a
  // prefix followed by two, four or eight little-endian value bytes.
  assign cs_first = (field_byte_total == 4'd0);

  always_comb begin
    if (b == CS_PREFIX_2) begin
      cs_total_sel = CS_TOTAL_2;
    end else if (b == CS_PREFIX_4) begin
      cs_total_sel = CS_TOTAL_4;
    end else begin
      cs_total_sel = CS_TOTAL_8;
    end
  end

  assign cs_done = cs_first ? (b < CS_PREFIX_2) : (idx_inc >= IDX_W'(field_byte_total));
  assign cs_val  = cs_first ? {56'd0, b} : acc_ins;

  // Field result of the current byte, and the truncation error.
  logic        res_valid;
  out_word_t   res_word;
  logic        err;
  out_word_t   err_word;
  logic        do_enter;
  phase_t      enter_phase;
  phase_t      work_phase;

  always_comb begin
    phase_next            = phase;
    field_byte_index_next = field_byte_index;
    field_byte_total_next = field_byte_total;
    value_acc_next        = value_acc;
    bytes_remaining_next  = bytes_remaining;
    items_remaining_next  = items_remaining;
    res_valid             = 1'b0;
    res_word.field_kind   = FK_HASH_BYTE;
    res_word.field_value  = {56'd0, b};
    res_word.record_end   = 1'b0;
    do_enter              = 1'b0;
    enter_phase           = PH_START;

    // At a record start the register picks the first field. The index,
    // total and accumulator are already clear there. An unused kind drops
    // the byte.
    work_phase = phase;
    if (phase == PH_START) begin
      case (record_kind)
        RK_SPEND:   work_phase = PH_HASH;
        RK_OUTPUT:  work_phase = PH_AMOUNT;
        RK_WITNESS: work_phase = PH_COUNT;
        default:    work_phase = PH_START;
      endcase
      phase_next = work_phase;
    end

    // Shared stepping for CompactSize fields that are not yet complete.
    if (((work_phase == PH_SLEN) || (work_phase == PH_OSLEN) ||
         (work_phase == PH_COUNT) || (work_phase == PH_ILEN)) && !cs_done) begin
      if (cs_first) begin
        field_byte_total_next = cs_total_sel;
        field_byte_index_next = '0;
        value_acc_next        = '0;
      end else begin
        field_byte_index_next = idx_inc;
        value_acc_next        = acc_ins;
      end
    end

    case (work_phase)
      PH_START: begin
      end
      PH_HASH: begin
        res_valid             = 1'b1;
        res_word.field_kind   = FK_HASH_BYTE;
        field_byte_index_next = idx_inc;
        if (idx_inc >= IDX_W'(HASH_BYTES)) begin
          do_enter    = 1'b1;
          enter_phase = PH_INDEX;
        end
      end
      PH_INDEX: begin
        field_byte_index_next = idx_inc;
        value_acc_next        = acc_ins;
        if (idx_inc >= IDX_W'(INDEX_BYTES)) begin
          res_valid            = 1'b1;
          res_word.field_kind  = FK_INDEX;
          res_word.field_value = acc_ins;
          do_enter             = 1'b1;
          enter_phase          = PH_SLEN;
        end
      end
      PH_SLEN: begin
        if (cs_done) begin
          res_valid            = 1'b1;
          res_word.field_kind  = FK_SCRIPT_LEN;
          res_word.field_value = cs_val;
          bytes_remaining_next = cs_val;
          do_enter             = 1'b1;
          enter_phase          = (cs_val == 64'd0) ? PH_SEQ : PH_SCRIPT;
        end
      end
      PH_SCRIPT: begin
        res_valid            = 1'b1;
        res_word.field_kind  = FK_SCRIPT_BYTE;
        bytes_remaining_next = bytes_dec;
        if (bytes_dec == 64'd0) begin
          do_enter    = 1'b1;
          enter_phase = PH_SEQ;
        end
      end
      PH_SEQ: begin
        field_byte_index_next = idx_inc;
        value_acc_next        = acc_ins;
        if (idx_inc >= IDX_W'(SEQ_BYTES)) begin
          res_valid            = 1'b1;
          res_word.field_kind  = FK_SEQUENCE;
          res_word.field_value = acc_ins;
          res_word.record_end  = 1'b1;
          do_enter             = 1'b1;
          enter_phase          = PH_START;
        end
      end
      PH_AMOUNT: begin
        field_byte_index_next = idx_inc;
        value_acc_next        = acc_ins;
        if (idx_inc >= IDX_W'(AMOUNT_BYTES)) begin
          res_valid            = 1'b1;
          res_word.field_kind  = FK_AMOUNT;
          res_word.field_value = acc_ins;
          do_enter             = 1'b1;
          enter_phase          = PH_OSLEN;
        end
      end
      PH_OSLEN: begin
        if (cs_done) begin
          res_valid            = 1'b1;
          res_word.field_kind  = FK_SCRIPT_LEN;
          res_word.field_value = cs_val;
          res_word.record_end  = (cs_val == 64'd0);
          bytes_remaining_next = cs_val;
          do_enter             = 1'b1;
          enter_phase          = (cs_val == 64'd0) ? PH_START : PH_OSCRIPT;
        end
      end
      PH_OSCRIPT: begin
        res_valid            = 1'b1;
        res_word.field_kind  = FK_SCRIPT_BYTE;
        res_word.record_end  = (bytes_dec == 64'd0);
        bytes_remaining_next = bytes_dec;
        if (bytes_dec == 64'd0) begin
          do_enter    = 1'b1;
          enter_phase = PH_START;
        end
      end
      PH_COUNT: begin
        if (cs_done) begin
          res_valid            = 1'b1;
          res_word.field_kind  = FK_ITEM_COUNT;
          res_word.field_value = cs_val;
          res_word.record_end  = (cs_val == 64'd0);
          items_remaining_next = cs_val;
          do_enter             = 1'b1;
          enter_phase          = (cs_val == 64'd0) ? PH_START : PH_ILEN;
        end
      end
      PH_ILEN: begin
        if (cs_done) begin
          res_valid            = 1'b1;
          res_word.field_kind  = FK_ITEM_LEN;
          res_word.field_value = cs_val;
          res_word.record_end  = (cs_val == 64'd0) && (items_dec == 64'd0);
          items_remaining_next = items_dec;
          bytes_remaining_next = cs_val;
          do_enter             = 1'b1;
          if (cs_val != 64'd0) begin
            enter_phase = PH_ITEM;
          end else if (items_dec == 64'd0) begin
            enter_phase = PH_START;
          end else begin
            enter_phase = PH_ILEN;
          end
        end
      end
      PH_ITEM: begin
        res_valid            = 1'b1;
        res_word.field_kind  = FK_ITEM_BYTE;
        res_word.record_end  = (bytes_dec == 64'd0) && (items_remaining == 64'd0);
        bytes_remaining_next = bytes_dec;
        if (bytes_dec == 64'd0) begin
          do_enter    = 1'b1;
          enter_phase = (items_remaining == 64'd0) ? PH_START : PH_ILEN;
        end
      end
      default: begin
        do_enter    = 1'b1;
        enter_phase = PH_START;
      end
    endcase

    // Moving to a new field clears the per-field counters.
    if (do_enter) begin
      phase_next            = enter_phase;
      field_byte_index_next = '0;
      field_byte_total_next = 4'd0;
      value_acc_next        = '0;
    end

    // A last byte that leaves the record open reports truncation and
    // restarts the parser from a clean record start.
    err = in_data.end_of_buffer && (phase_next != PH_START);
    if (err) begin
      phase_next            = PH_START;
      field_byte_index_next = '0;
      field_byte_total_next = 4'd0;
      value_acc_next        = '0;
      bytes_remaining_next  = '0;
      items_remaining_next  = '0;
    end
  end

  assign err_word.field_kind  = FK_TRUNCATED;
  assign err_word.field_value = 64'd0;
  assign err_word.record_end  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_START;
      field_byte_index <= '0;
      field_byte_total <= 4'd0;
      value_acc        <= '0;
      bytes_remaining  <= '0;
      items_remaining  <= '0;
    end else if (in_fire) begin
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      field_byte_total <= field_byte_total_next;
      value_acc        <= value_acc_next;
      bytes_remaining  <= bytes_remaining_next;
      items_remaining  <= items_remaining_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  // Up to two words enter per accepted byte: the field word first, then the
  // error word. One word leaves per output handshake.
  out_word_t              rq [RQ_DEPTH];
  logic [RQ_PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [RQ_PTR_W-1:0]    rd_ptr;
  logic [RQ_CNT_W-1:0]    count;
  logic [1:0]             push_n;
  out_word_t              slot0;

  assign push_n      = in_fire ? ({1'b0, res_valid} + {1'b0, err}) : 2'd0;
  assign slot0       = res_valid ? res_word : err_word;
  assign wr_ptr_next = wr_ptr + 1'b1;

  assign in_ready  = (count <= RQ_CNT_W'(RQ_DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = rq[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      rq[wr_ptr] <= slot0;
    end
    if (push_n == 2'd2) begin
      rq[wr_ptr_next] <= err_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RQ_PTR_W'(push_n);
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + RQ_CNT_W'(push_n) - RQ_CNT_W'(out_fire);
    end
  end

endmodule

[tb/tb_tx_record_stream_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tx_record_stream_parser
// Self-checking bench for the byte-serial transaction record parser. A short
// directed table is followed by random streams of spend, output and witness
// records. The streams include truncations, noise and register changes. Each
// accepted byte is run through a local field decoder. Every output word is
// compared against the oldest expected field still waiting.
// ----------------------------------------------------------------------------
module tb_tx_record_stream_parser import txrsp_pkg::*; ();

  localparam int          ITEMS          = 1300;
  localparam int          IDLE_PCT       = 18;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          MAX_REPORTS    = 10;
  localparam int          NO_CHANGE      = -1;
  localparam int          MAX_ITEMS      = 8;
  localparam logic [63:0] PAYLOAD_CUT    = 64'd200;
  localparam logic [7:0]  CS_PREFIX_8    = 8'hFF;
  // The kind code that the register holds but that names no record.
  localparam logic [1:0]  RK_UNUSED      = 2'd3;
  localparam logic [PADDR_W-1:0] KIND_ADDR = PADDR_W'(4 * int'(REG_RECORD_KIND));

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_word_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  tx_record_stream_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 100 MHz clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Field decoder. This mirrors the parser's state. It is kept separate from
  // the RTL so that a shared mistake cannot hide itself.
  // --------------------------------------------------------------------------
  logic [1:0]  kind_cfg;      // record_kind as last written
  phase_t      phase;
  logic [5:0]  byte_pos;      // bytes taken in the current field
  logic [5:0]  byte_span;     // CompactSize value bytes, 0 before the prefix
  logic [63:0] accum;
  logic [63:0] payload_left;  // script or item bytes still to come
  logic [63:0] items_left;    // witness items whose length is still to come

  out_word_t   step_fields[$];     // fields produced by one byte
  out_word_t   pending_fields[$];  // fields the DUT still owes us

  function void jump_phase(phase_t p);
    phase     = p;
    byte_pos  = '0;
    byte_span = '0;
    accum     = '0;
  endfunction

  function void add_field(field_kind_t k, logic [63:0] v, logic e);
    out_word_t f;
    f = '{field_kind: k, field_value: v, record_end: e};
    step_fields.insert(step_fields.size(), f);
  endfunction

  // Little-endian fixed field. Returns 1 once n bytes have been collected.
  function bit gather_le(logic [7:0] b, logic [5:0] n);
    accum    = accum | (64'(b) << (8 * byte_pos[2:0]));
    byte_pos = byte_pos + 6'd1;
    return byte_pos >= n;
  endfunction

  // CompactSize field. A first byte below 0xFD is the whole value. The three
  // prefixes announce 2, 4 or 8 little-endian value bytes. Non-minimal forms
  // are taken as encoded.
  function bit gather_compact(logic [7:0] b);
    if (byte_span == '0) begin
      if (b < CS_PREFIX_2) begin
        accum = 64'(b);
        return 1'b1;
      end
      byte_span = (b == CS_PREFIX_2) ? 6'(CS_TOTAL_2) :
                  (b == CS_PREFIX_4) ? 6'(CS_TOTAL_4) : 6'(CS_TOTAL_8);
      byte_pos  = '0;
      accum     = '0;
      return 1'b0;
    end
    return gather_le(b, byte_span);
  endfunction

  // Runs one accepted byte through the decoder and fills step_fields.
  // Returns 1 when the byte was dropped at a record start with the unused kind.
  function bit decode_byte(in_word_t w);
    logic [7:0]  b;
    logic [63:0] v;
    bit          last;
    b = w.data_byte;
    step_fields.delete();
    // The record kind is sampled only when a new record begins.
    if (phase == PH_START) begin
      case (kind_cfg)
        RK_SPEND:   jump_phase(PH_HASH);
        RK_OUTPUT:  jump_phase(PH_AMOUNT);
        RK_WITNESS: jump_phase(PH_COUNT);
        default:    return 1'b1;
      endcase
    end
    case (phase)
      PH_HASH: begin
        add_field(FK_HASH_BYTE, 64'(b), 1'b0);
        byte_pos = byte_pos + 6'd1;
        if (byte_pos >= HASH_BYTES_DEF) jump_phase(PH_INDEX);
      end
      PH_INDEX: begin
        if (gather_le(b, 6'(INDEX_BYTES))) begin
          add_field(FK_INDEX, accum, 1'b0);
          jump_phase(PH_SLEN);
        end
      end
      PH_SLEN: begin
        if (gather_compact(b)) begin
          v = accum;
          add_field(FK_SCRIPT_LEN, v, 1'b0);
          payload_left = v;
          jump_phase(v == 0 ? PH_SEQ : PH_SCRIPT);
        end
      end
      PH_SCRIPT: begin
        add_field(FK_SCRIPT_BYTE, 64'(b), 1'b0);
        payload_left = payload_left - 64'd1;
        if (payload_left == 0) jump_phase(PH_SEQ);
      end
      PH_SEQ: begin
        if (gather_le(b, 6'(SEQ_BYTES))) begin
          add_field(FK_SEQUENCE, accum, 1'b1);
          jump_phase(PH_START);
        end
      end
      PH_AMOUNT: begin
        if (gather_le(b, 6'(AMOUNT_BYTES))) begin
          add_field(FK_AMOUNT, accum, 1'b0);
          jump_phase(PH_OSLEN);
        end
      end
      PH_OSLEN: begin
        // An empty script ends the output record on the length word.
        if (gather_compact(b)) begin
          v = accum;
          add_field(FK_SCRIPT_LEN, v, v == 0);
          payload_left = v;
          jump_phase(v == 0 ? PH_START : PH_OSCRIPT);
        end
      end
      PH_OSCRIPT: begin
        payload_left = payload_left - 64'd1;
        add_field(FK_SCRIPT_BYTE, 64'(b), payload_left == 0);
        if (payload_left == 0) jump_phase(PH_START);
      end
      PH_COUNT: begin
        if (gather_compact(b)) begin
          v = accum;
          items_left = v;
          add_field(FK_ITEM_COUNT, v, v == 0);
          jump_phase(v == 0 ? PH_START : PH_ILEN);
        end
      end
      PH_ILEN: begin
        if (gather_compact(b)) begin
          v = accum;
          items_left = items_left - 64'd1;
          last = (items_left == 0);
          add_field(FK_ITEM_LEN, v, v == 0 && last);
          payload_left = v;
          jump_phase(v != 0 ? PH_ITEM : (last ? PH_START : PH_ILEN));
        end
      end
      PH_ITEM: begin
        payload_left = payload_left - 64'd1;
        last = (payload_left == 0) && (items_left == 0);
        add_field(FK_ITEM_BYTE, 64'(b), last);
        if (payload_left == 0) jump_phase(last ? PH_START : PH_ILEN);
      end
      default: jump_phase(PH_START);
    endcase
    // When the last available byte leaves the record unfinished, the parser
    // reports the truncation after any field and starts over.
    if (w.end_of_buffer && phase != PH_START) begin
      add_field(FK_TRUNCATED, 64'd0, 1'b1);
      jump_phase(PH_START);
      payload_left = '0;
      items_left   = '0;
    end
    return 1'b0;
  endfunction

  // --------------------------------------------------------------------------
  // Random stream builders. Records are written into stim_q as input words.
  // --------------------------------------------------------------------------
  in_word_t stim_q[$];

  function void put(logic [7:0] b, bit eob = 1'b0);
    in_word_t w;
    w = '{data_byte: b, end_of_buffer: eob};
    stim_q.insert(stim_q.size(), w);
  endfunction

  function logic [7:0] rnd_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function logic [63:0] rnd_u64();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) put(v[8*i +: 8]);
  endfunction

  // Any length that cannot be streamed out in full. Records that carry one
  // are always cut short by an end-of-buffer byte.
  function logic [63:0] huge_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (v <= PAYLOAD_CUT) v = ~v;
    return v;
  endfunction

  // Lengths are mostly short so that records stay small.
  function logic [63:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 64'($urandom_range(0, 2));
    if (r < 75) return 64'($urandom_range(3, 10));
    if (r < 95) return 64'($urandom_range(11, 40));
    return huge_value();
  endfunction

  // Mostly minimal encodings, with a share of the wider forms.
  function void put_compact(logic [63:0] v);
    if (v < 64'(CS_PREFIX_2) && $urandom_range(5) != 0) begin
      put(v[7:0]);
    end else if (v <= 64'hFFFF && $urandom_range(2) != 0) begin
      put(CS_PREFIX_2);
      put_le(v, 2);
    end else if (v <= 64'hFFFF_FFFF && $urandom_range(1) != 0) begin
      put(CS_PREFIX_4);
      put_le(v, 4);
    end else begin
      put(CS_PREFIX_8);
      put_le(v, 8);
    end
  endfunction

  // Returns 1 when the length was too long and the record got cut off.
  function bit put_payload(logic [63:0] len);
    if (len > PAYLOAD_CUT) begin
      repeat ($urandom_range(0, 3)) put(rnd_byte());
      put(rnd_byte(), 1'b1);
      return 1'b1;
    end
    repeat (int'(len)) put(rnd_byte());
    return 1'b0;
  endfunction

  function void put_noise();
    repeat ($urandom_range(1, 6)) put(rnd_byte(), $urandom_range(9) < 3);
  endfunction

  function void gen_spend();
    logic [63:0] len;
    repeat (HASH_BYTES_DEF) put(rnd_byte());
    put_le(rnd_u64(), int'(INDEX_BYTES));
    len = pick_len();
    put_compact(len);
    if (put_payload(len)) return;
    put_le(rnd_u64(), int'(SEQ_BYTES));
  endfunction

  function void gen_output();
    logic [63:0] len;
    put_le(rnd_u64(), int'(AMOUNT_BYTES));
    len = pick_len();
    put_compact(len);
    void'(put_payload(len));
  endfunction

  function void gen_witness();
    logic [63:0] cnt;
    logic [63:0] len;
    int          r;
    r = $urandom_range(99);
    if (r < 15)      cnt = '0;
    else if (r < 90) cnt = 64'($urandom_range(1, 4));
    else             cnt = huge_value();
    put_compact(cnt);
    if (cnt > MAX_ITEMS) begin
      // Too many items to send, so the record ends on a truncation.
      put(rnd_byte());
      put(rnd_byte(), 1'b1);
      return;
    end
    repeat (int'(cnt)) begin
      len = pick_len();
      put_compact(len);
      if (put_payload(len)) return;
    end
  endfunction

  // One record of the given kind. Some records are replaced by noise, some
  // are cut short by end-of-buffer, and some are flagged on their final byte.
  function void gen_record(logic [1:0] k);
    int s;
    int p;
    int r;
    s = stim_q.size();
    if ($urandom_range(99) < 5) begin
      put_noise();
      return;
    end
    case (k)
      RK_SPEND:   gen_spend();
      RK_OUTPUT:  gen_output();
      RK_WITNESS: gen_witness();
      default:    put_noise();
    endcase
    r = $urandom_range(99);
    if (r < 10 && stim_q.size() - s >= 2) begin
      p = $urandom_range(s, stim_q.size() - 2);
      stim_q[p].end_of_buffer = 1'b1;
      while (stim_q.size() > p + 1) void'(stim_q.pop_back());
    end else if (r < 25) begin
      stim_q[stim_q.size() - 1].end_of_buffer = 1'b1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Every output word that the DUT hands over is matched against
  // the oldest field still expected.
  // --------------------------------------------------------------------------
  int        err_cnt;
  int        n_bytes;
  int        n_counted;
  int        n_ignored;
  int        n_fields;
  int        n_records;
  int        n_trunc;
  int        n_phases;
  int        quiet_cycles;
  bit        steady;        // both sides run without idling while set
  out_word_t want;

  task automatic note_error(string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("%0t ERROR %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_fields++;
      if (out_data.record_end) n_records++;
      if (out_data.field_kind == FK_TRUNCATED) n_trunc++;
      if (pending_fields.size() == 0) begin
        note_error($sformatf("unexpected word: kind %0d value %h end %b",
                             out_data.field_kind, out_data.field_value,
                             out_data.record_end));
      end else begin
        want = pending_fields.pop_front();
        if (out_data.field_kind !== want.field_kind ||
            out_data.field_value !== want.field_value ||
            out_data.record_end !== want.record_end) begin
          note_error($sformatf({"word mismatch: expected kind %0d value %h end %b,",
                                " got kind %0d value %h end %b"},
                               want.field_kind, want.field_value, want.record_end,
                               out_data.field_kind, out_data.field_value,
                               out_data.record_end));
        end
      end
    end
  end

  // The receiver stalls at random, except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Cycles without any handshake on either channel or the register port.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t watchdog: no handshake for %0d cycles, %0d words outstanding",
             $realtime, WATCHDOG_LIMIT, pending_fields.size());
    $display("tb_tx_record_stream_parser: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Offers one input word and returns at the edge that accepts it. It then
  // decodes the word. Where the directed table types in the expected fields,
  // those are queued instead of the decoder's, though the decoder still runs
  // to keep its state in step.
  task automatic send_word(in_word_t w, int n_typed = -1,
                           out_word_t t0 = '0, out_word_t t1 = '0);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    n_bytes++;
    if (decode_byte(w)) n_ignored++;
    else                n_counted++;
    if (n_typed < 0) begin
      foreach (step_fields[i]) pending_fields.insert(pending_fields.size(), step_fields[i]);
    end else begin
      if (n_typed > 0) pending_fields.insert(pending_fields.size(), t0);
      if (n_typed > 1) pending_fields.insert(pending_fields.size(), t1);
    end
  endtask

  // Writes record_kind while the parser is idle, then reads it back. The
  // parser may be part way through a record. The new kind then applies from
  // the next record start.
  task automatic set_record_kind(logic [1:0] k);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_fields.size() != 0);
    // A byte that produces no field may still be inside the parser.
    repeat (SETTLE_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KIND_ADDR;
    pwdata  <= 32'(k);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    kind_cfg = k;
    n_phases++;
    // Read back.
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(k)) begin
      note_error($sformatf("record_kind read back %h, expected %h", prdata, 32'(k)));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Directed table. A kind other than NO_CHANGE writes the register before
  // the row's byte is sent. A count of -1 defers the row to the decoder.
  // --------------------------------------------------------------------------
  typedef struct {
    int        set_kind;
    in_word_t  w;
    int        n_typed;
    out_word_t t0;
    out_word_t t1;
  } stim_row_t;

  stim_row_t stim_rows[$];

  function void stim_row(int set_kind, logic [7:0] b, bit eob, int n_typed = -1,
                         field_kind_t k0 = FK_HASH_BYTE, logic [63:0] v0 = '0,
                         bit e0 = 1'b0, field_kind_t k1 = FK_HASH_BYTE,
                         logic [63:0] v1 = '0, bit e1 = 1'b0);
    stim_row_t row;
    row = '{set_kind: set_kind,
            w: '{data_byte: b, end_of_buffer: eob},
            n_typed: n_typed,
            t0: '{field_kind: k0, field_value: v0, record_end: e0},
            t1: '{field_kind: k1, field_value: v1, record_end: e1}};
    stim_rows.insert(stim_rows.size(), row);
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [1:0] k;
    int         budget;
    int         s;
    int         p;

    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    steady    = 1'b0;
    err_cnt   = 0;
    n_bytes   = 0;
    n_counted = 0;
    n_ignored = 0;
    n_fields  = 0;
    n_records = 0;
    n_trunc   = 0;
    n_phases  = 0;
    quiet_cycles = 0;
    // Reset state of the decoder: spend records, parser at a record start.
    kind_cfg     = RK_SPEND;
    jump_phase(PH_START);
    payload_left = '0;
    items_left   = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Out of reset the kind is spend. A hash byte comes straight back, and
    // a flagged byte inside the hash is followed by a truncation error.
    stim_row(NO_CHANGE, 8'h00, 1'b0, 1, FK_HASH_BYTE, 64'h00, 1'b0);
    stim_row(NO_CHANGE, 8'hFF, 1'b1, 2, FK_HASH_BYTE, 64'hFF, 1'b0,
             FK_TRUNCATED, 64'd0, 1'b1);
    // Output record with a little-endian amount and an empty script. The
    // empty script closes the record on its length word.
    stim_row(RK_OUTPUT, 8'h01, 1'b0, 0);
    stim_row(NO_CHANGE, 8'h02, 1'b0);
    stim_row(NO_CHANGE, 8'h03, 1'b0);
    stim_row(NO_CHANGE, 8'h04, 1'b0);
    stim_row(NO_CHANGE, 8'h05, 1'b0);
    stim_row(NO_CHANGE, 8'h06, 1'b0);
    stim_row(NO_CHANGE, 8'h07, 1'b0);
    stim_row(NO_CHANGE, 8'h08, 1'b0, 1, FK_AMOUNT, 64'h0807_0605_0403_0201, 1'b0);
    stim_row(NO_CHANGE, 8'h00, 1'b0, 1, FK_SCRIPT_LEN, 64'd0, 1'b1);
    // Witness: a zero count ends the record at once.
    stim_row(RK_WITNESS, 8'h00, 1'b0, 1, FK_ITEM_COUNT, 64'd0, 1'b1);
    // Two items, the first empty. The flagged last byte completes the record,
    // so no error follows.
    stim_row(NO_CHANGE, 8'h02, 1'b0);
    stim_row(NO_CHANGE, 8'h00, 1'b0);
    stim_row(NO_CHANGE, 8'h01, 1'b0);
    stim_row(NO_CHANGE, 8'hAB, 1'b1);
    // Non-minimal four-byte count of one. The buffer then ends on the prefix
    // of the item length.
    stim_row(NO_CHANGE, CS_PREFIX_4, 1'b0);
    stim_row(NO_CHANGE, 8'h01, 1'b0);
    stim_row(NO_CHANGE, 8'h00, 1'b0);
    stim_row(NO_CHANGE, 8'h00, 1'b0);
    stim_row(NO_CHANGE, 8'h00, 1'b0);
    stim_row(NO_CHANGE, CS_PREFIX_8, 1'b1, 1, FK_TRUNCATED, 64'd0, 1'b1);
    // The unused kind drops bytes at a record start, even flagged ones.
    stim_row(RK_UNUSED, 8'hAA, 1'b1, 0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].set_kind != NO_CHANGE) set_record_kind(2'(stim_rows[i].set_kind));
      send_word(stim_rows[i].w, stim_rows[i].n_typed, stim_rows[i].t0, stim_rows[i].t1);
    end

    // Random phases. Each phase writes a kind and streams a batch of records.
    // Now and then a batch ends inside a record, so the next kind starts
    // only once that record has finished.
    n_counted = 0;
    while (n_counted < ITEMS) begin
      k = (n_phases % 7 == 6) ? RK_UNUSED : 2'(n_phases % 3);
      set_record_kind(k);
      stim_q.delete();
      budget = (k == RK_UNUSED) ? $urandom_range(4, 10) : $urandom_range(60, 200);
      while (stim_q.size() < budget) gen_record(k);
      if (k != RK_UNUSED && $urandom_range(99) < 20) begin
        s = stim_q.size();
        gen_record(k);
        if (stim_q.size() - s >= 2) begin
          p = $urandom_range(s, stim_q.size() - 2);
          while (stim_q.size() > p + 1) void'(stim_q.pop_back());
        end
      end
      foreach (stim_q[i]) begin
        // One long stretch with no idling on either side.
        steady = (n_counted >= 500 && n_counted < 750);
        send_word(stim_q[i]);
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_fields.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_fields.size() != 0) begin
      note_error($sformatf("%0d expected words never arrived", pending_fields.size()));
    end

    $display("Streamed %0d bytes over %0d record_kind settings; %0d were dropped",
             n_bytes, n_phases, n_ignored);
    $display("Checked %0d words: %0d record ends, %0d truncation errors, %0d mismatches",
             n_fields, n_records, n_trunc, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_tx_record_stream_parser: done, clean");
    end else begin
      $display("tb_tx_record_stream_parser: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/txrsp_pkg.sv
rtl/tx_record_stream_parser.sv
tb/tb_tx_record_stream_parser.sv
